>>> src/tfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_pkg
// shared widths, register indexes and the tag carried through the dividers
// ----------------------------------------------------------------------------
package tfm_pkg;

    localparam int TICK_W  = 64;
    localparam int RATIO_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STAGES = TICK_W;

    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOMINATOR = 1'b1;

    localparam logic [TICK_W-1:0] S64_MAX = {1'b0, {(TICK_W-1){1'b1}}};
    localparam logic [TICK_W-1:0] S64_MIN = {1'b1, {(TICK_W-1){1'b0}}};

    // side information that rides along a divider pipeline
    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [TICK_W-1:0] qprod;
    } div_tag_t;

endpackage

>>> src/tfm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfm_divider
// pipelined unsigned 64 by 32 divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tfm_divider
    import tfm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [TICK_W-1:0]  in_dividend,
    input  div_tag_t           in_tag,
    input  logic [RATIO_W-1:0] divisor,
    output logic               out_valid,
    output logic [TICK_W-1:0]  out_quotient,
    output logic [RATIO_W-1:0] out_remainder,
    output div_tag_t           out_tag
);

    logic [DIV_STAGES:0]  valid_reg;
    logic [TICK_W-1:0]    dvd_reg [DIV_STAGES+1];
    logic [RATIO_W-1:0]   rem_reg [DIV_STAGES+1];
    div_tag_t             tag_reg [DIV_STAGES+1];

    logic [TICK_W-1:0]    dvd_next [DIV_STAGES];
    logic [RATIO_W-1:0]   rem_next [DIV_STAGES];

    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            logic [RATIO_W:0] trial;
            logic             ge;
            trial = {rem_reg[i], dvd_reg[i][TICK_W-1]};
            ge    = trial >= {1'b0, divisor};
            rem_next[i] = ge ? RATIO_W'(trial - {1'b0, divisor}) : trial[RATIO_W-1:0];
            // quotient bits shift in where dividend bits leave
            dvd_next[i] = {dvd_reg[i][TICK_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0] <= in_dividend;
            rem_reg[0] <= '0;
            tag_reg[0] <= in_tag;
            for (int i = 0; i < DIV_STAGES; i++) begin
                dvd_reg[i+1] <= dvd_next[i];
                rem_reg[i+1] <= rem_next[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid     = valid_reg[DIV_STAGES];
    assign out_quotient  = dvd_reg[DIV_STAGES];
    assign out_remainder = rem_reg[DIV_STAGES];
    assign out_tag       = tag_reg[DIV_STAGES];

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && (divisor != '0) |-> out_remainder < divisor)
        else $error("remainder not below divisor");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg) && (!out_valid || $stable(out_quotient)))
        else $error("divider moved while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> valid_reg == '0)
        else $error("divider valid bits survive reset");

endmodule

>>> src/timebase_fraction_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timebase_fraction_multiply_unit
// scales a signed tick count to nanoseconds by numerator / denominator
// ----------------------------------------------------------------------------
// Usage: write ratio_numerator (index 0) and ratio_denominator (index 1)
// through the cfg channel while no word is in flight; both reset to 1 and a
// denominator of 0 or 1 selects the plain saturated product.
// Input words arrive on s_valid / s_ready with s_tick_count; results leave on
// m_valid / m_ready with m_nanoseconds and m_saturated.
// The path from the accepting edge to m_valid runs through one input stage,
// two restoring dividers of 65 stages each (a load stage, then one quotient
// bit per stage; tick split by the denominator, then the remainder product
// by the denominator), two multiply stages and the output register.
// One word per cycle unless m_ready stalls; every stage advances together.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline freezes and s_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets the ratio registers to 1; s_ready and
// cfg_ready stay low during reset, and the cfg channel is always ready
// otherwise.
// ----------------------------------------------------------------------------
module timebase_fraction_multiply_unit
    import tfm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TICK_W-1:0]    s_tick_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TICK_W-1:0]    m_nanoseconds,
    output logic                 m_saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATIO_W-1:0]   cfg_wdata
);

    logic [RATIO_W-1:0] num_reg, den_reg;
    logic [RATIO_W-1:0] den_eff;
    logic               adv;

    assign cfg_ready = aresetn;
    assign adv       = !m_valid || m_ready;
    assign s_ready   = aresetn && adv;
    assign den_eff   = (den_reg <= RATIO_W'(1)) ? RATIO_W'(1) : den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= RATIO_W'(1);
            den_reg <= RATIO_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUMERATOR:   num_reg <= cfg_wdata;
                REG_DENOMINATOR: den_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage: sign and magnitude
    logic              v0_reg;
    logic              neg0_reg;
    logic [TICK_W-1:0] mag0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (adv) v0_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg0_reg <= s_tick_count[TICK_W-1];
            mag0_reg <= s_tick_count[TICK_W-1] ? TICK_W'(-s_tick_count) : s_tick_count;
        end
    end

    div_tag_t           tag0;
    logic               v1;
    logic [TICK_W-1:0]  quo1;
    logic [RATIO_W-1:0] rem1;
    div_tag_t           tag1;

    always_comb begin
        tag0       = '0;
        tag0.neg   = neg0_reg;
    end

    tfm_divider u_div_tick (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (v0_reg),
        .in_dividend   (mag0_reg),
        .in_tag        (tag0),
        .divisor       (den_eff),
        .out_valid     (v1),
        .out_quotient  (quo1),
        .out_remainder (rem1),
        .out_tag       (tag1)
    );

    // multiply stage one: partial products
    logic              vm1_reg, negm1_reg;
    logic [TICK_W-1:0] pp_lo_reg, pp_hi_reg, rp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vm1_reg <= 1'b0;
        else if (adv) vm1_reg <= v1;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            negm1_reg <= tag1.neg;
            pp_lo_reg <= quo1[RATIO_W-1:0] * num_reg;
            pp_hi_reg <= quo1[TICK_W-1:RATIO_W] * num_reg;
            rp_reg    <= rem1 * num_reg;
        end
    end

    // multiply stage two: combine and clamp
    logic [TICK_W+RATIO_W-1:0] qmag;
    logic                      qsat, rsat;
    logic [TICK_W-1:0]         qprod, rclamp;

    always_comb begin
        qmag = {{RATIO_W{1'b0}}, pp_lo_reg} + {pp_hi_reg, {RATIO_W{1'b0}}};
        if (negm1_reg) begin
            qsat = (|qmag[TICK_W+RATIO_W-1:TICK_W]) || (qmag[TICK_W-1] && |qmag[TICK_W-2:0]);
            rsat = rp_reg[TICK_W-1] && |rp_reg[TICK_W-2:0];
        end else begin
            qsat = |qmag[TICK_W+RATIO_W-1:TICK_W-1];
            rsat = rp_reg[TICK_W-1];
        end
        if (qsat) qprod = negm1_reg ? S64_MIN : S64_MAX;
        else      qprod = negm1_reg ? TICK_W'(-qmag[TICK_W-1:0]) : qmag[TICK_W-1:0];
        // magnitude of the clamped remainder product
        if (rsat) rclamp = negm1_reg ? S64_MIN : S64_MAX;
        else      rclamp = rp_reg;
    end

    logic              vm2_reg;
    logic [TICK_W-1:0] rmag_reg;
    div_tag_t          tagm2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vm2_reg <= 1'b0;
        else if (adv) vm2_reg <= vm1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rmag_reg        <= rclamp;
            tagm2_reg.neg   <= negm1_reg;
            tagm2_reg.sat   <= qsat || rsat;
            tagm2_reg.qprod <= qprod;
        end
    end

    logic               v3;
    logic [TICK_W-1:0]  quo3;
    logic [RATIO_W-1:0] rem3;
    div_tag_t           tag3;

    tfm_divider u_div_part (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (adv),
        .in_valid      (vm2_reg),
        .in_dividend   (rmag_reg),
        .in_tag        (tagm2_reg),
        .divisor       (den_eff),
        .out_valid     (v3),
        .out_quotient  (quo3),
        .out_remainder (rem3),
        .out_tag       (tag3)
    );

    // final add, saturating
    logic [TICK_W-1:0] part;
    logic [TICK_W+1:0] sum;
    logic [TICK_W-1:0] ns_next;
    logic              sat_next;

    always_comb begin
        part = tag3.neg ? TICK_W'(-quo3) : quo3;
        sum  = {{2{tag3.qprod[TICK_W-1]}}, tag3.qprod} + {{2{part[TICK_W-1]}}, part};
        sat_next = tag3.sat;
        ns_next  = sum[TICK_W-1:0];
        if (sum[TICK_W+1:TICK_W-1] != '0 && sum[TICK_W+1:TICK_W-1] != '1) begin
            sat_next = 1'b1;
            ns_next  = sum[TICK_W+1] ? S64_MIN : S64_MAX;
        end
    end

    logic              m_valid_reg, m_sat_reg;
    logic [TICK_W-1:0] m_ns_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= v3;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_ns_reg  <= ns_next;
            m_sat_reg <= sat_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_nanoseconds = m_ns_reg;
    assign m_saturated   = m_sat_reg;

    a_zero_numerator: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (num_reg == '0) |-> (m_nanoseconds == '0) && !m_saturated)
        else $error("zero numerator gave non-zero result");

    a_unit_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (num_reg == RATIO_W'(1)) && (den_reg <= RATIO_W'(1)) |-> !m_saturated)
        else $error("unit ratio flagged saturation");

    a_remainder_zero_on_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        v3 && (den_reg <= RATIO_W'(1)) |-> (quo3 == '0) && (rem3 == '0))
        else $error("unit denominator left a remainder part");

endmodule

>>> test/timebase_fraction_multiply_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timebase_fraction_multiply_unit_test
// checks tick-to-nanosecond scaling against a behavioural predictor, with
// bursty input, a stalling receiver and several ratio settings
// ----------------------------------------------------------------------------
module timebase_fraction_multiply_unit_test
    import tfm_pkg::*;
;

    localparam int LATENCY = 133;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TICK_W-1:0]    s_tick_count = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [TICK_W-1:0]    m_nanoseconds;
    logic                 m_saturated;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [RATIO_W-1:0]   cfg_wdata = '0;

    timebase_fraction_multiply_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        logic [TICK_W-1:0] ns;
        logic              sat;
    } scaled_t;

    logic [TICK_W-1:0] pending_ticks[$];
    scaled_t           expected_scaled[$];
    logic [RATIO_W-1:0] num_reg = 1, den_reg = 1;
    int errors = 0;
    int accepted = 0;
    int received = 0;
    int sat_seen = 0;
    bit hold_off = 1'b0;

    function automatic longint sat_scale(longint a, longint k, ref bit flag);
        longint mx, mn;
        mx = 64'sh7FFFFFFFFFFFFFFF;
        mn = -mx - 1;
        if (k != 0 && (a < mn / k || mx / k < a)) begin
            flag = 1'b1;
            return (a >= 0) ? mx : mn;
        end
        return a * k;
    endfunction

    function automatic scaled_t scale_ticks(logic [TICK_W-1:0] t);
        longint ticks, num, den, q, r, part, prod, mx, mn, res;
        bit flag;
        scaled_t o;
        ticks = t;
        num = longint'({32'd0, num_reg});
        den = longint'({32'd0, den_reg});
        flag = 1'b0;
        mx = 64'sh7FFFFFFFFFFFFFFF;
        mn = -mx - 1;
        if (den <= 1) begin
            res = sat_scale(ticks, num, flag);
        end else begin
            q = ticks / den;
            r = ticks % den;
            part = sat_scale(r, num, flag) / den;
            prod = sat_scale(q, num, flag);
            if (part > 0 && prod > mx - part) begin
                flag = 1'b1;
                res = mx;
            end else if (part < 0 && prod < mn - part) begin
                flag = 1'b1;
                res = mn;
            end else begin
                res = prod + part;
            end
        end
        o.ns = res;
        o.sat = flag;
        return o;
    endfunction

    // driver: bursts with gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_scaled.push_back(scale_ticks(s_tick_count));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_valid <= 1'b1;
                    s_tick_count <= pending_ticks.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                received++;
                if (m_saturated) sat_seen++;
                if (expected_scaled.size() == 0) begin
                    $display("%0t: unexpected word ns=%h sat=%b", $time, m_nanoseconds,
                             m_saturated);
                    errors++;
                end else begin
                    scaled_t e;
                    e = expected_scaled.pop_front();
                    if (m_nanoseconds !== e.ns) begin
                        $display("%0t: nanoseconds expected %h actual %h", $time, e.ns,
                                 m_nanoseconds);
                        errors++;
                    end
                    if (m_saturated !== e.sat) begin
                        $display("%0t: saturated expected %b actual %b", $time, e.sat,
                                 m_saturated);
                        errors++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 23;
            if (hold_off) m_ready <= 1'b0;
            else if (stall_phase < 6) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_ratio(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NUMERATOR) num_reg = val;
        else den_reg = val;
    endtask

    task automatic drain;
        wait (pending_ticks.size() == 0 && !s_valid && expected_scaled.size() == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        // a last word may have gone out just as the first check passed
        wait (pending_ticks.size() == 0 && !s_valid && expected_scaled.size() == 0);
    endtask

    function automatic logic [TICK_W-1:0] random_ticks();
        logic [TICK_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = $signed(v[15:0]);
            1: v = $signed(v[35:0]);
            2: v = S64_MAX - $urandom_range(0, 3);
            3: v = S64_MIN + $urandom_range(0, 3);
            default: ;
        endcase
        return v;
    endfunction

    logic [RATIO_W-1:0] ratio_sets[8][2] = '{
        '{32'd1, 32'd1}, '{32'hFFFFFFFF, 32'hFFFFFFFF}, '{32'd1000000000, 32'd24000000},
        '{32'd125, 32'd3}, '{32'hFFFFFFFF, 32'd1}, '{32'd7, 32'd0},
        '{32'd0, 32'd5}, '{32'd3, 32'hFFFFFFFF}};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: reset ratio, field extremes
        pending_ticks = '{64'd0, 64'd1, {64{1'b1}}, S64_MAX, S64_MIN, 64'hAAAAAAAAAAAAAAAA,
                          64'h5555555555555555};
        drain();
        foreach (ratio_sets[i]) begin
            write_ratio(REG_NUMERATOR, ratio_sets[i][0]);
            write_ratio(REG_DENOMINATOR, ratio_sets[i][1]);
            pending_ticks.push_back(S64_MAX);
            pending_ticks.push_back(S64_MIN);
            pending_ticks.push_back(-64'sd1);
            pending_ticks.push_back(64'd2);
            for (int n = 0; n < 160; n++) pending_ticks.push_back(random_ticks());
            if (i == 2) begin
                // long receiver hold-off while words keep arriving
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            drain();
        end
        $display("tb: %0d words in, %0d out, %0d saturated, %0d ratio settings",
                 accepted, received, sat_seen, 8);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> timebase_fraction_multiply_unit.f
src/tfm_pkg.sv
src/tfm_divider.sv
src/timebase_fraction_multiply_unit.sv
test/timebase_fraction_multiply_unit_test.sv
